// ===== sv/bap_pkg.sv =====
// bap_pkg: shared constants, types and helper functions of the buddy page allocator
// used by bap_page_mem, bap_engine and buddy_page_allocator; depends on nothing
package bap_pkg;

    localparam int TOP_ORDER  = 10;
    localparam int NUM_ORDERS = TOP_ORDER + 1;
    localparam int PAGE_AW    = 14;
    localparam int CNT_W      = 15;
    localparam int ORD_W      = 4;
    localparam int WORD_W     = 1 + ORD_W + 2 * CNT_W;

    localparam logic [CNT_W-1:0] MAX_PAGES   = 15'd16384;
    localparam logic [CNT_W-1:0] TOTAL_RESET = 15'd16384;
    localparam logic [CNT_W-1:0] MAX_ALLOC   = 15'd1024;
    localparam logic [CNT_W-1:0] NIL_LINK    = 15'h7FFF;

    // page word: head flag, order, next link, prev link
    typedef struct packed {
        logic                we;
        logic [PAGE_AW-1:0]  addr;
        logic [WORD_W-1:0]   wdata;
    } t_mem_req;

    typedef struct packed {
        logic                kind;
        logic [CNT_W-1:0]    count;
        logic [PAGE_AW-1:0]  index;
    } t_req;

    typedef struct packed {
        logic                ok;
        logic [PAGE_AW-1:0]  first;
        logic [CNT_W-1:0]    free;
    } t_res;

    typedef enum logic [4:0] {
        S_CLR, S_FMT, S_IDLE, S_AL_FIND, S_AL_SPLIT, S_RR_INIT, S_RR_STEP,
        S_RB_TEST, S_RB_CHK, S_RB_MERGE, S_P0, S_P1, S_P2,
        S_U0, S_U1, S_U2, S_U3, S_U4, S_U5, S_DONE
    } t_state;

    // alignment order of a page index, capped at the top order
    function automatic logic [ORD_W-1:0] f_align_order(input logic [CNT_W-1:0] v);
        logic [ORD_W-1:0] k;
        logic             found;
        k     = ORD_W'(TOP_ORDER);
        found = 1'b0;
        for (int i = 0; i < TOP_ORDER; i++) begin
            if (!found && v[i]) begin
                k     = ORD_W'(i);
                found = 1'b1;
            end
        end
        return k;
    endfunction

    function automatic logic [ORD_W-1:0] f_floor_log2(input logic [CNT_W-1:0] v);
        logic [ORD_W-1:0] k;
        k = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (v[i]) k = ORD_W'(i);
        end
        return k;
    endfunction

    // smallest order whose block holds v pages, v at most 2^TOP_ORDER
    function automatic logic [ORD_W-1:0] f_ceil_log2(input logic [CNT_W-1:0] v);
        logic [ORD_W-1:0] k;
        k = ORD_W'(TOP_ORDER);
        for (int i = TOP_ORDER; i >= 0; i--) begin
            if ((CNT_W'(1) << i) >= v) k = ORD_W'(i);
        end
        return k;
    endfunction

endpackage

// ===== sv/buddy_page_allocator.sv =====
// buddy_page_allocator: top level with config register, request intake and result register
// uses bap_pkg and bap_engine
// Each request is one transfer in and one transfer out. An alloc refused on its count
// or a free of zero pages goes straight to the result. Other allocs and frees are
// sequenced over the single page-store port as list pushes, unlinks and buddy probes,
// handling one split or merge order at a time.
// After reset, and after a write of total_pages while the engine is idle, the block
// clears the page store, then formats it, and takes no request meanwhile. The next
// request is taken while a finished result still waits in the output register.
module buddy_page_allocator import bap_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic [CNT_W-1:0]   i_page_count,
    input  logic [PAGE_AW-1:0] i_page_index,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_ok,
    output logic [PAGE_AW-1:0] o_first_page,
    output logic [CNT_W-1:0]   o_pages_free
);

    logic [CNT_W-1:0] r_total;
    logic             cfg_wr;
    logic             fmt;
    logic [CNT_W-1:0] wval;
    logic             eng_idle;
    logic             eng_done;
    t_res             eng_res;
    t_req             req;
    logic             res_ready;
    logic             r_out_valid;
    t_res             r_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign fmt    = cfg_wr && !paddr[2];
    assign wval   = pwdata[CNT_W-1:0];
    assign prdata = paddr[2] ? 32'd0 : {{(32-CNT_W){1'b0}}, r_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_RESET;
        end else if (fmt) begin
            r_total <= (wval > MAX_PAGES) ? MAX_PAGES : wval;
        end
    end

    // no request transfer in the cycle of a register write
    assign o_in_ready = eng_idle && !cfg_wr;
    assign req.kind   = i_kind;
    assign req.count  = i_page_count;
    assign req.index  = i_page_index;
    assign res_ready  = !r_out_valid || i_out_ready;

    bap_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fmt       (fmt),
        .i_total     (r_total),
        .i_start     (i_in_valid && o_in_ready),
        .i_req       (req),
        .i_res_ready (res_ready),
        .o_idle      (eng_idle),
        .o_done      (eng_done),
        .o_res       (eng_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_done && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_done && res_ready) begin
            r_out <= eng_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_ok         = r_out.ok;
    assign o_first_page = r_out.first;
    assign o_pages_free = r_out.free;

endmodule

// ===== sv/bap_page_mem.sv =====
// bap_page_mem: per-page store of head flag, order and list links
// single port, registered read data; uses bap_pkg
module bap_page_mem import bap_pkg::*; (
    input  logic              i_clk,
    input  t_mem_req          i_req,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [1 << PAGE_AW];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bap_engine.sv =====
// bap_engine: sequencer for clear, format, alloc and free on the page store
// keeps the per-order list heads and free count; uses bap_pkg and bap_page_mem
module bap_engine import bap_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fmt,
    input  logic [CNT_W-1:0] i_total,
    input  logic             i_start,
    input  t_req             i_req,
    input  logic             i_res_ready,
    output logic             o_idle,
    output logic             o_done,
    output t_res             o_res
);

    t_state r_state, n_state, r_ret, n_ret;
    logic [PAGE_AW-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_heads [NUM_ORDERS];
    logic [CNT_W-1:0]   n_heads [NUM_ORDERS];
    logic [CNT_W-1:0]   r_free, n_free;
    logic [CNT_W-1:0]   r_fp, n_fp, r_fn, n_fn;
    logic [ORD_W-1:0]   r_fk, n_fk;
    logic [PAGE_AW-1:0] r_pp, n_pp;
    logic [ORD_W-1:0]   r_pk, n_pk;
    logic [CNT_W-1:0]   r_h, n_h;
    logic [PAGE_AW-1:0] r_up, n_up;
    logic [ORD_W-1:0]   r_uk, n_uk;
    logic [CNT_W-1:0]   r_nx, n_nx, r_pv, n_pv;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [ORD_W-1:0]   r_want, n_want;
    logic [PAGE_AW-1:0] r_ap, n_ap;
    logic [ORD_W-1:0]   r_ak, n_ak;
    logic [CNT_W-1:0]   r_base, n_base, r_rn, n_rn;
    logic               r_tail, n_tail;
    logic [PAGE_AW-1:0] r_idx, n_idx, r_b, n_b;
    logic [ORD_W-1:0]   r_rk, n_rk;
    logic               r_ok, n_ok;
    logic [PAGE_AW-1:0] r_first, n_first;

    t_mem_req          mem_req;
    logic [WORD_W-1:0] mem_rdata;

    bap_page_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret   <= n_ret;
        r_heads <= n_heads;
        r_free  <= n_free;
        r_fp    <= n_fp;
        r_fn    <= n_fn;
        r_fk    <= n_fk;
        r_pp    <= n_pp;
        r_pk    <= n_pk;
        r_h     <= n_h;
        r_up    <= n_up;
        r_uk    <= n_uk;
        r_nx    <= n_nx;
        r_pv    <= n_pv;
        r_n     <= n_n;
        r_want  <= n_want;
        r_ap    <= n_ap;
        r_ak    <= n_ak;
        r_base  <= n_base;
        r_rn    <= n_rn;
        r_tail  <= n_tail;
        r_idx   <= n_idx;
        r_b     <= n_b;
        r_rk    <= n_rk;
        r_ok    <= n_ok;
        r_first <= n_first;
    end

    always_comb begin
        logic [CNT_W-1:0]   sz;
        logic [CNT_W-1:0]   lim;
        logic [CNT_W-1:0]   rnc;
        logic [CNT_W:0]     sum;
        logic [ORD_W-1:0]   k;
        logic [ORD_W-1:0]   ka;
        logic [ORD_W-1:0]   kb;
        logic               hit;
        logic [PAGE_AW-1:0] b;

        n_state = r_state;
        n_ret   = r_ret;
        n_cnt   = r_cnt;
        n_heads = r_heads;
        n_free  = r_free;
        n_fp    = r_fp;
        n_fn    = r_fn;
        n_fk    = r_fk;
        n_pp    = r_pp;
        n_pk    = r_pk;
        n_h     = r_h;
        n_up    = r_up;
        n_uk    = r_uk;
        n_nx    = r_nx;
        n_pv    = r_pv;
        n_n     = r_n;
        n_want  = r_want;
        n_ap    = r_ap;
        n_ak    = r_ak;
        n_base  = r_base;
        n_rn    = r_rn;
        n_tail  = r_tail;
        n_idx   = r_idx;
        n_b     = r_b;
        n_rk    = r_rk;
        n_ok    = r_ok;
        n_first = r_first;
        mem_req = '0;
        sz      = '0;
        lim     = '0;
        rnc     = '0;
        sum     = '0;
        k       = '0;
        ka      = '0;
        kb      = '0;
        hit     = 1'b0;
        b       = '0;

        case (r_state)
            S_CLR: begin
                mem_req.we   = 1'b1;
                mem_req.addr = r_cnt;
                n_cnt        = r_cnt + 1'b1;
                for (int i = 0; i < NUM_ORDERS; i++) n_heads[i] = NIL_LINK;
                n_free = i_total;
                if (r_cnt == '1) begin
                    n_state = S_FMT;
                    n_fp    = '0;
                    n_fn    = i_total;
                    n_fk    = ORD_W'(TOP_ORDER);
                end
            end
            S_FMT: begin
                sz = CNT_W'(1) << r_fk;
                if (r_fn >= sz) begin
                    n_pp    = r_fp[PAGE_AW-1:0];
                    n_pk    = r_fk;
                    n_fp    = r_fp + sz;
                    n_fn    = r_fn - sz;
                    n_ret   = S_FMT;
                    n_state = S_P0;
                end else if (r_fk == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_fk = r_fk - 1'b1;
                end
            end
            S_IDLE: begin
                if (i_fmt) begin
                    n_state = S_CLR;
                    n_cnt   = '0;
                end else if (i_start) begin
                    n_first = '0;
                    if (i_req.kind) begin
                        n_ok = 1'b1;
                        if (i_req.count == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_base  = {1'b0, i_req.index};
                            n_rn    = i_req.count;
                            n_tail  = 1'b0;
                            n_state = S_RR_INIT;
                        end
                    end else if (i_req.count != '0 && i_req.count <= MAX_ALLOC &&
                                 i_req.count <= r_free) begin
                        n_want  = f_ceil_log2(i_req.count);
                        n_n     = i_req.count;
                        n_state = S_AL_FIND;
                    end else begin
                        n_ok    = 1'b0;
                        n_state = S_DONE;
                    end
                end
            end
            S_AL_FIND: begin
                // smallest non-empty list at or above the wanted order
                for (int i = TOP_ORDER; i >= 0; i--) begin
                    if (ORD_W'(i) >= r_want && !r_heads[i][CNT_W-1]) begin
                        hit = 1'b1;
                        k   = ORD_W'(i);
                    end
                end
                if (hit) begin
                    n_ap    = r_heads[k][PAGE_AW-1:0];
                    n_ak    = k;
                    n_up    = r_heads[k][PAGE_AW-1:0];
                    n_uk    = k;
                    n_ret   = S_AL_SPLIT;
                    n_state = S_U0;
                end else begin
                    n_ok    = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_AL_SPLIT: begin
                if (r_ak > r_want) begin
                    k    = r_ak - 1'b1;
                    sz   = CNT_W'(1) << k;
                    n_ak = k;
                    // upper half past the store is dropped
                    if ({1'b0, r_ap} + sz < i_total) begin
                        n_pp    = PAGE_AW'({1'b0, r_ap} + sz);
                        n_pk    = k;
                        n_ret   = S_AL_SPLIT;
                        n_state = S_P0;
                    end
                end else begin
                    sz      = CNT_W'(1) << r_want;
                    n_free  = r_free - r_n;
                    n_ok    = 1'b1;
                    n_first = r_ap;
                    if (r_n != sz) begin
                        n_base  = {1'b0, r_ap} + r_n;
                        n_rn    = sz - r_n;
                        n_tail  = 1'b1;
                        n_state = S_RR_INIT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RR_INIT: begin
                if (r_base >= i_total) begin
                    n_state = S_DONE;
                end else begin
                    lim  = i_total - r_base;
                    rnc  = (r_rn > lim) ? lim : r_rn;
                    n_rn = rnc;
                    if (!r_tail) begin
                        sum    = {1'b0, r_free} + {1'b0, rnc};
                        n_free = (sum > {1'b0, i_total}) ? i_total : sum[CNT_W-1:0];
                    end
                    n_state = S_RR_STEP;
                end
            end
            S_RR_STEP: begin
                if (r_rn == '0) begin
                    n_state = S_DONE;
                end else begin
                    ka      = f_align_order(r_base);
                    kb      = f_floor_log2(r_rn);
                    k       = (ka < kb) ? ka : kb;
                    sz      = CNT_W'(1) << k;
                    n_idx   = r_base[PAGE_AW-1:0];
                    n_rk    = k;
                    n_base  = r_base + sz;
                    n_rn    = r_rn - sz;
                    n_state = S_RB_TEST;
                end
            end
            S_RB_TEST: begin
                b = r_idx ^ (PAGE_AW'(1) << r_rk);
                if (r_rk < ORD_W'(TOP_ORDER) && {1'b0, b} < i_total) begin
                    mem_req.addr = b;
                    n_b          = b;
                    n_state      = S_RB_CHK;
                end else begin
                    n_pp    = r_idx;
                    n_pk    = r_rk;
                    n_ret   = S_RR_STEP;
                    n_state = S_P0;
                end
            end
            S_RB_CHK: begin
                if (mem_rdata[WORD_W-1] && mem_rdata[WORD_W-2 -: ORD_W] == r_rk) begin
                    n_up    = r_b;
                    n_uk    = r_rk;
                    n_ret   = S_RB_MERGE;
                    n_state = S_U0;
                end else begin
                    n_pp    = r_idx;
                    n_pk    = r_rk;
                    n_ret   = S_RR_STEP;
                    n_state = S_P0;
                end
            end
            S_RB_MERGE: begin
                n_idx   = r_idx & r_b;
                n_rk    = r_rk + 1'b1;
                n_state = S_RB_TEST;
            end
            S_P0: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = r_pp;
                mem_req.wdata = {1'b1, r_pk, r_heads[r_pk], NIL_LINK};
                n_heads[r_pk] = {1'b0, r_pp};
                n_h           = r_heads[r_pk];
                n_state       = r_heads[r_pk][CNT_W-1] ? r_ret : S_P1;
            end
            S_P1: begin
                mem_req.addr = r_h[PAGE_AW-1:0];
                n_state      = S_P2;
            end
            S_P2: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = r_h[PAGE_AW-1:0];
                mem_req.wdata = {mem_rdata[WORD_W-1:CNT_W], 1'b0, r_pp};
                n_state       = r_ret;
            end
            S_U0: begin
                mem_req.addr = r_up;
                n_state      = S_U1;
            end
            S_U1: begin
                n_nx          = mem_rdata[2*CNT_W-1:CNT_W];
                n_pv          = mem_rdata[CNT_W-1:0];
                mem_req.we    = 1'b1;
                mem_req.addr  = r_up;
                mem_req.wdata = {1'b0, mem_rdata[WORD_W-2:0]};
                n_state       = S_U2;
            end
            S_U2: begin
                if (!r_pv[CNT_W-1]) begin
                    mem_req.addr = r_pv[PAGE_AW-1:0];
                    n_state      = S_U3;
                end else begin
                    n_heads[r_uk] = r_nx;
                    n_state       = S_U4;
                end
            end
            S_U3: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = r_pv[PAGE_AW-1:0];
                mem_req.wdata = {mem_rdata[WORD_W-1:2*CNT_W], r_nx, mem_rdata[CNT_W-1:0]};
                n_state       = S_U4;
            end
            S_U4: begin
                if (!r_nx[CNT_W-1]) begin
                    mem_req.addr = r_nx[PAGE_AW-1:0];
                    n_state      = S_U5;
                end else begin
                    n_state = r_ret;
                end
            end
            S_U5: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = r_nx[PAGE_AW-1:0];
                mem_req.wdata = {mem_rdata[WORD_W-1:CNT_W], r_pv};
                n_state       = r_ret;
            end
            S_DONE: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_done      = (r_state == S_DONE);
    assign o_res.ok    = r_ok;
    assign o_res.first = r_first;
    assign o_res.free  = r_free;

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !mem_req.we)
        else $error("page store written while idle");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_free <= i_total)
        else $error("free count above total pages");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_ok) |-> r_first == '0)
        else $error("refused alloc carries a page");

    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> r_state != S_IDLE)
        else $error("accepted request left engine idle");

endmodule
